>>> hw/rtl/baro_pkg.sv
// Shared types and constants for the barometric compensation core.
package baro_pkg;

    localparam int CAL_BIAS = 16384;

    typedef enum logic [1:0] {
        CFG_TEMP_CALIB = 2'd0,
        CFG_PRESS_A    = 2'd1,
        CFG_PRESS_B    = 2'd2,
        CFG_PRESS_C    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [23:0] raw_pressure;
        logic [23:0] raw_temperature;
    } t_in_item;

    typedef struct packed {
        logic [22:0]        pressure_pa_x64;
        logic signed [15:0] temperature_c_x256;
        logic               saturated;
    } t_out_item;

    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [7:0]  t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [7:0]  p3;
        logic [7:0]  p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [7:0]  p7;
        logic [7:0]  p8;
        logic [15:0] p9;
        logic [7:0]  p10;
        logic [7:0]  p11;
    } t_calib;

    typedef struct packed {
        logic [23:0]        up;
        logic signed [15:0] temp;
        logic signed [23:0] tq;
        logic               sat;
    } t_temp_res;

endpackage

>>> hw/rtl/baro_temp.sv
// Four-stage pipeline that linearizes the raw temperature.
module baro_temp
    import baro_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    input  t_calib    i_cal,
    output logic      o_valid,
    input  logic      i_ready,
    output t_temp_res o_res
);

    logic [4:1] r_v;
    logic [5:1] w_adv;

    logic signed [24:0] r1_pt;
    logic [23:0]        r1_up;
    logic signed [41:0] r2_ma;
    logic signed [49:0] r2_mb;
    logic [23:0]        r2_up;
    logic signed [60:0] r3_tl;
    logic [23:0]        r3_up;
    t_temp_res          r4_res;

    logic signed [24:0] w_pt;
    logic signed [41:0] w_ma;
    logic signed [49:0] w_mb;
    logic signed [60:0] w_tl;
    logic signed [60:0] w_tr40;
    logic signed [60:0] w_tr32;
    logic signed [20:0] w_tf;
    logic signed [28:0] w_qf;
    t_temp_res          n_res;

    always_comb begin
        w_adv[5] = i_ready;
        for (int k = 4; k >= 1; k--) begin
            w_adv[k] = !r_v[k] || w_adv[k+1];
        end
    end

    assign o_ready = w_adv[1];
    assign o_valid = r_v[4];
    assign o_res   = r4_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_adv[1]) r_v[1] <= i_valid;
            for (int k = 2; k <= 4; k++) begin
                if (w_adv[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    assign w_pt   = $signed({1'b0, i_item.raw_temperature}) - $signed({1'b0, i_cal.t1, 8'h00});
    assign w_ma   = r1_pt * $signed({1'b0, i_cal.t2});
    assign w_mb   = r1_pt * r1_pt;
    assign w_tl   = (61'(r2_ma) <<< 18) + r2_mb * $signed(i_cal.t3);
    assign w_tr40 = r3_tl + (61'sd1 <<< 39);
    assign w_tr32 = r3_tl + (61'sd1 <<< 31);
    assign w_tf   = $signed(w_tr40[60:40]);
    assign w_qf   = $signed(w_tr32[60:32]);

    always_comb begin
        n_res.up = r3_up;
        n_res.sat = 1'b0;
        if (w_tf > 21'sd32767) begin
            n_res.temp = 16'sh7FFF;
            n_res.sat  = 1'b1;
        end else if (w_tf < -21'sd32768) begin
            n_res.temp = -16'sh8000;
            n_res.sat  = 1'b1;
        end else begin
            n_res.temp = w_tf[15:0];
        end
        if (w_qf > 29'sd8388607) begin
            n_res.tq = 24'sh7FFFFF;
        end else if (w_qf < -29'sd8388608) begin
            n_res.tq = -24'sh800000;
        end else begin
            n_res.tq = w_qf[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r1_pt <= w_pt;
            r1_up <= i_item.raw_pressure;
        end
        if (w_adv[2]) begin
            r2_ma <= w_ma;
            r2_mb <= w_mb;
            r2_up <= r1_up;
        end
        if (w_adv[3]) begin
            r3_tl <= w_tl;
            r3_up <= r2_up;
        end
        if (w_adv[4]) begin
            r4_res <= n_res;
        end
    end

endmodule

>>> hw/rtl/baro_press.sv
// Seven-stage pipeline that evaluates the pressure polynomial and saturates.
module baro_press
    import baro_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_temp_res i_res,
    input  t_calib    i_cal,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    logic [7:1] r_v;
    logic [8:1] w_adv;

    // Per-stage payload carried alongside each computation.
    logic [23:0]        r5_up, r6_up, r7_up, r8_up;
    logic signed [15:0] r5_temp, r6_temp, r7_temp, r8_temp, r9_temp, r10_temp;
    logic               r5_sat, r6_sat, r7_sat, r8_sat, r9_sat, r10_sat;
    logic signed [23:0] r5_tq;
    logic signed [31:0] r5_tsq;
    logic signed [40:0] r5_o6, r6_o6, r7_o6;
    logic signed [40:0] r5_s2, r6_s2, r7_s2;
    logic signed [31:0] r5_d10;
    logic [47:0]        r5_uu;
    logic signed [39:0] r6_tcu, r6_o7, r6_s3, r6_cub, r7_o7, r7_s3;
    logic signed [33:0] r6_dq;
    logic signed [40:0] r7_o8;
    logic signed [42:0] r7_s4;
    logic signed [58:0] r7_udq;
    logic signed [64:0] r7_cup;
    logic signed [47:0] r8_off, r9_off;
    logic signed [37:0] r8_sens;
    logic signed [34:0] r8_qa;
    logic signed [40:0] r8_ct, r9_ct;
    logic signed [62:0] r9_us;
    logic signed [59:0] r9_qu;
    logic signed [55:0] r10_acc;
    t_out_item          r11_item;

    logic signed [16:0] w_p1b, w_p2b;
    logic signed [47:0] w_sq;
    logic signed [48:0] w_sqr;
    logic signed [40:0] w_o6, w_s2;
    logic signed [31:0] w_d10;
    logic signed [55:0] w_cu, w_cur;
    logic signed [39:0] w_o7, w_s3;
    logic signed [33:0] w_dq;
    logic signed [56:0] w_cb, w_cbr;
    logic signed [47:0] w_o8, w_s4;
    logic signed [58:0] w_udq;
    logic signed [64:0] w_cup;
    logic signed [47:0] w_off;
    logic signed [49:0] w_sens, w_sensr;
    logic signed [58:0] w_qar;
    logic signed [64:0] w_ctr;
    logic signed [62:0] w_us, w_usr;
    logic signed [59:0] w_qu, w_qur;
    logic signed [55:0] w_acc, w_pr;
    logic signed [37:0] w_pf;
    t_out_item          n_item;

    always_comb begin
        w_adv[8] = i_ready;
        for (int k = 7; k >= 1; k--) begin
            w_adv[k] = !r_v[k] || w_adv[k+1];
        end
    end

    assign o_ready = w_adv[1];
    assign o_valid = r_v[7];
    assign o_item  = r11_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_adv[1]) r_v[1] <= i_valid;
            for (int k = 2; k <= 7; k++) begin
                if (w_adv[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    assign w_p1b = $signed(i_cal.p1) - 17'(CAL_BIAS);
    assign w_p2b = $signed(i_cal.p2) - 17'(CAL_BIAS);

    assign w_sq  = i_res.tq * i_res.tq;
    assign w_sqr = w_sq + 49'sd32768;
    assign w_o6  = $signed({1'b0, i_cal.p6}) * i_res.tq;
    assign w_s2  = w_p2b * i_res.tq;
    assign w_d10 = $signed(i_cal.p10) * i_res.tq;

    assign w_cu  = r5_tsq * r5_tq;
    assign w_cur = w_cu + 56'sd32768;
    assign w_o7  = $signed(i_cal.p7) * r5_tsq;
    assign w_s3  = $signed(i_cal.p3) * r5_tsq;
    assign w_dq  = $signed({i_cal.p9, 16'h0000}) + r5_d10;
    assign w_cb  = $signed({1'b0, r5_uu}) * $signed(i_cal.p11);
    assign w_cbr = w_cb + 57'sd65536;

    assign w_o8  = $signed(i_cal.p8) * r6_tcu + 48'sd64;
    assign w_s4  = $signed(i_cal.p4) * r6_tcu + 48'sd16;
    assign w_udq = $signed({1'b0, r6_up}) * r6_dq;
    assign w_cup = r6_cub * $signed({1'b0, r6_up});

    assign w_off   = $signed({1'b0, i_cal.p5, 27'h0}) + (48'(r7_o6) <<< 2) + r7_o7 + r7_o8;
    assign w_sens  = (50'(w_p1b) <<< 28) + (50'(r7_s2) <<< 3) + r7_s3 + r7_s4;
    assign w_sensr = w_sens + 50'sd2048;
    assign w_qar   = r7_udq + (59'sd1 <<< 23);
    assign w_ctr   = r7_cup + (65'sd1 <<< 23);

    assign w_us = $signed({1'b0, r8_up}) * r8_sens;
    assign w_qu = r8_qa * $signed({1'b0, r8_up});

    assign w_usr = r9_us + 63'sd2048;
    assign w_qur = r9_qu + 60'sd32768;
    assign w_acc = r9_off + $signed(w_usr[62:12]) + $signed(w_qur[59:16]) + r9_ct;

    assign w_pr = r10_acc + 56'sd131072;
    assign w_pf = $signed(w_pr[55:18]);

    always_comb begin
        n_item.temperature_c_x256 = r10_temp;
        if (w_pf < 38'sd0) begin
            n_item.pressure_pa_x64 = '0;
            n_item.saturated       = 1'b1;
        end else if (w_pf > 38'sd8388607) begin
            n_item.pressure_pa_x64 = '1;
            n_item.saturated       = 1'b1;
        end else begin
            n_item.pressure_pa_x64 = w_pf[22:0];
            n_item.saturated       = r10_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r5_up   <= i_res.up;
            r5_temp <= i_res.temp;
            r5_sat  <= i_res.sat;
            r5_tq   <= i_res.tq;
            r5_tsq  <= w_sqr[47:16];
            r5_o6   <= w_o6;
            r5_s2   <= w_s2;
            r5_d10  <= w_d10;
            r5_uu   <= i_res.up * i_res.up;
        end
        if (w_adv[2]) begin
            r6_up   <= r5_up;
            r6_temp <= r5_temp;
            r6_sat  <= r5_sat;
            r6_o6   <= r5_o6;
            r6_s2   <= r5_s2;
            r6_tcu  <= w_cur[55:16];
            r6_o7   <= w_o7;
            r6_s3   <= w_s3;
            r6_dq   <= w_dq;
            r6_cub  <= w_cbr[56:17];
        end
        if (w_adv[3]) begin
            r7_up   <= r6_up;
            r7_temp <= r6_temp;
            r7_sat  <= r6_sat;
            r7_o6   <= r6_o6;
            r7_s2   <= r6_s2;
            r7_o7   <= r6_o7;
            r7_s3   <= r6_s3;
            r7_o8   <= $signed(w_o8[47:7]);
            r7_s4   <= $signed(w_s4[47:5]);
            r7_udq  <= w_udq;
            r7_cup  <= w_cup;
        end
        if (w_adv[4]) begin
            r8_up   <= r7_up;
            r8_temp <= r7_temp;
            r8_sat  <= r7_sat;
            r8_off  <= w_off;
            r8_sens <= w_sensr[49:12];
            r8_qa   <= w_qar[58:24];
            r8_ct   <= w_ctr[64:24];
        end
        if (w_adv[5]) begin
            r9_temp <= r8_temp;
            r9_sat  <= r8_sat;
            r9_off  <= r8_off;
            r9_ct   <= r8_ct;
            r9_us   <= w_us;
            r9_qu   <= w_qu;
        end
        if (w_adv[6]) begin
            r10_temp <= r9_temp;
            r10_sat  <= r9_sat;
            r10_acc  <= w_acc;
        end
        if (w_adv[7]) begin
            r11_item <= n_item;
        end
    end

endmodule

>>> hw/rtl/baro_temp_pressure_compensation_core.sv
// Top level of the barometric temperature and pressure compensation core.
// The core takes one item per clock unless the output stalls. Items pass four
// stages that linearize the temperature and seven that evaluate the pressure
// polynomial, the last being the output register. Every stage holds its item
// while the next cannot take it, so bubbles close up and an output stall backs
// up the pipeline stage by stage. The user must write raw calibration words via
// the write port only while no item is in flight; the core does not check this.
module baro_temp_pressure_compensation_core
    import baro_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_item
);

    logic [39:0] r_temp_calib;
    logic [47:0] r_press_a;
    logic [47:0] r_press_b;
    logic [31:0] r_press_c;
    t_calib      w_cal;
    t_temp_res   w_tres;
    logic        w_tvalid;
    logic        w_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_calib <= '0;
            r_press_a    <= '0;
            r_press_b    <= '0;
            r_press_c    <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TEMP_CALIB: r_temp_calib <= i_cfg_data[39:0];
                CFG_PRESS_A:    r_press_a    <= i_cfg_data;
                CFG_PRESS_B:    r_press_b    <= i_cfg_data;
                CFG_PRESS_C:    r_press_c    <= i_cfg_data[31:0];
                default:        r_press_c    <= r_press_c;
            endcase
        end
    end

    assign w_cal.t1  = r_temp_calib[15:0];
    assign w_cal.t2  = r_temp_calib[31:16];
    assign w_cal.t3  = r_temp_calib[39:32];
    assign w_cal.p1  = r_press_a[15:0];
    assign w_cal.p2  = r_press_a[31:16];
    assign w_cal.p3  = r_press_a[39:32];
    assign w_cal.p4  = r_press_a[47:40];
    assign w_cal.p5  = r_press_b[15:0];
    assign w_cal.p6  = r_press_b[31:16];
    assign w_cal.p7  = r_press_b[39:32];
    assign w_cal.p8  = r_press_b[47:40];
    assign w_cal.p9  = r_press_c[15:0];
    assign w_cal.p10 = r_press_c[23:16];
    assign w_cal.p11 = r_press_c[31:24];

    baro_temp u_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_item),
        .i_cal   (w_cal),
        .o_valid (w_tvalid),
        .i_ready (w_tready),
        .o_res   (w_tres)
    );

    baro_press u_press (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_tvalid),
        .o_ready (w_tready),
        .i_res   (w_tres),
        .i_cal   (w_cal),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_item)
    );

endmodule
